/* rtl/dtvt_pkg.sv */
package dtvt_pkg;

    // default geometry and storage sizes
    localparam int DEF_TILE_SIZE        = 64;
    localparam int DEF_MAX_TILE_COLUMNS = 32;
    localparam int DEF_MAX_TILE_ROWS    = 32;
    localparam int DEF_MAX_BUFFERS      = 3;
    localparam int DEF_VERSION_BITS     = 16;

    // internal pixel coordinate width
    localparam int PIX_W = 16;

    // register reset values
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [1:0]  RST_BUFFER_COUNT = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BUFFER_COUNT = 2'd2;

    // result status codes
    localparam logic [1:0] ST_ROWS    = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_NOBUF   = 2'd2;
    localparam logic [1:0] ST_RELEASE = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_step;
        logic bump;
        logic scan_init;
        logic scan_wr;
        logic emit_release;
        logic emit_empty;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic cfg_clear;
        logic clr_done;
        logic is_release;
        logic is_empty;
        logic wrap;
        logic grid_end;
    } sts_t;

    // clamp a signed coordinate into [lo, hi]
    function automatic logic signed [PIX_W:0] clamp_s(
        input logic signed [PIX_W:0] v,
        input logic signed [PIX_W:0] lo,
        input logic signed [PIX_W:0] hi
    );
        logic signed [PIX_W:0] res;
        if (v < lo)
            res = lo;
        else if (v > hi)
            res = hi;
        else
            res = v;
        return res;
    endfunction

endpackage

/* rtl/dtvt_ram.sv */
module dtvt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/dtvt_ctrl.sv */
module dtvt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  dtvt_pkg::sts_t sts,
    output dtvt_pkg::cmd_t cmd,
    output logic           busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_WCLEAR,
        S_SCAN_RD,
        S_SCAN_WR
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register, reset starts with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.is_release)
                begin
                    cmd.emit_release = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (sts.is_empty)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.bump      = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = sts.wrap ? S_WCLEAR : S_SCAN_RD;
                end
            end
            S_WCLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_WR;
            end
            S_SCAN_WR:
            begin
                cmd.scan_wr = 1'b1;
                state_next  = sts.grid_end ? S_IDLE : S_SCAN_RD;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        // a frame size write restarts the clearing pass
        if (sts.cfg_clear)
        begin
            cmd        = '0;
            state_next = S_CLEAR;
        end
    end

endmodule

/* rtl/dtvt_datapath.sv */
module dtvt_datapath #(
    parameter int TILE_SIZE        = dtvt_pkg::DEF_TILE_SIZE,
    parameter int MAX_TILE_COLUMNS = dtvt_pkg::DEF_MAX_TILE_COLUMNS,
    parameter int MAX_TILE_ROWS    = dtvt_pkg::DEF_MAX_TILE_ROWS,
    parameter int MAX_BUFFERS      = dtvt_pkg::DEF_MAX_BUFFERS,
    parameter int VERSION_BITS     = dtvt_pkg::DEF_VERSION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               mode,
    input  logic signed [15:0] rect_left,
    input  logic signed [15:0] rect_top,
    input  logic signed [15:0] rect_right,
    input  logic signed [15:0] rect_bottom,
    input  logic [1:0]         release_index,
    input  dtvt_pkg::cmd_t     cmd,
    output dtvt_pkg::sts_t     sts,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic [1:0]         buffer_index,
    output logic [4:0]         tile_row,
    output logic [31:0]        column_mask,
    output logic [11:0]        damage_left,
    output logic [11:0]        damage_top,
    output logic [11:0]        damage_width,
    output logic [11:0]        damage_height,
    output logic               last
);

    localparam int PW         = dtvt_pkg::PIX_W;
    localparam int TILE_COUNT = MAX_TILE_ROWS * MAX_TILE_COLUMNS;
    localparam int AW         = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int XW         = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
    localparam int YW         = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
    localparam int BW         = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int VW         = VERSION_BITS;
    localparam logic [PW-1:0] TS    = PW'(TILE_SIZE);
    localparam logic [PW-1:0] CAP_W = PW'(MAX_TILE_COLUMNS * TILE_SIZE);
    localparam logic [PW-1:0] CAP_H = PW'(MAX_TILE_ROWS * TILE_SIZE);

    // configuration and control state
    logic [11:0]          width_reg;
    logic [11:0]          height_reg;
    logic [1:0]           bcount_reg;
    logic [VW-1:0]        ver_reg;
    logic [VW-1:0]        ver_next;
    logic                 ffp_reg;
    logic [MAX_BUFFERS-1:0] busy_reg;
    logic [AW-1:0]        clr_addr_reg;

    // captured item
    logic                 mode_reg;
    logic [1:0]           rel_idx_reg;
    logic [PW-1:0]        l_reg, t_reg, r_reg, b_reg;

    // scan counters
    logic [XW-1:0]        x_reg;
    logic [YW-1:0]        y_reg;
    logic [PW-1:0]        px_reg, py_reg;
    logic [AW-1:0]        base_reg;
    logic [31:0]          mask_reg;
    logic [BW-1:0]        sel_reg;
    logic                 have_buf_reg;

    // output word registers
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [1:0]           buffer_index_reg;
    logic [4:0]           tile_row_reg;
    logic [31:0]          column_mask_reg;
    logic [11:0]          damage_left_reg, damage_top_reg;
    logic [11:0]          damage_width_reg, damage_height_reg;
    logic                 last_reg;

    logic                 cfg_clear;
    logic [PW-1:0]        w_eff, h_eff;
    logic signed [PW:0]   cl, ct, cr, cb;
    logic [2:0]           nbuf;
    logic [BW-1:0]        sel_c;
    logic                 have_c;
    logic [AW-1:0]        scan_addr;
    logic [VW-1:0]        cur_q;
    logic [VW-1:0]        buf_q [MAX_BUFFERS];
    logic [VW-1:0]        buf_sel_q;
    logic                 cov;
    logic [VW-1:0]        new_cur;
    logic                 diff;
    logic [31:0]          mask_cur;
    logic                 row_end;
    logic                 grid_end;
    logic                 cur_we;
    logic [AW-1:0]        waddr;

    assign cfg_clear = cfg_we && ((cfg_index == dtvt_pkg::CFG_FRAME_WIDTH) ||
                                  (cfg_index == dtvt_pkg::CFG_FRAME_HEIGHT));

    // effective frame size
    always_comb
    begin
        w_eff = PW'(width_reg);
        if (w_eff == '0)
            w_eff = PW'(1);
        if (w_eff > CAP_W)
            w_eff = CAP_W;
        h_eff = PW'(height_reg);
        if (h_eff == '0)
            h_eff = PW'(1);
        if (h_eff > CAP_H)
            h_eff = CAP_H;
    end

    // rectangle clamp
    always_comb
    begin
        cl = dtvt_pkg::clamp_s((PW+1)'(rect_left), '0, signed'({1'b0, w_eff}));
        ct = dtvt_pkg::clamp_s((PW+1)'(rect_top), '0, signed'({1'b0, h_eff}));
        cr = dtvt_pkg::clamp_s((PW+1)'(rect_right), cl, signed'({1'b0, w_eff}));
        cb = dtvt_pkg::clamp_s((PW+1)'(rect_bottom), ct, signed'({1'b0, h_eff}));
        if (cl < 0)
            cl = '0;
    end

    // lowest free buffer among those in use
    always_comb
    begin
        if (bcount_reg < 2'd2)
            nbuf = 3'd2;
        else if (32'(bcount_reg) > MAX_BUFFERS)
            nbuf = 3'(MAX_BUFFERS);
        else
            nbuf = 3'(bcount_reg);
        sel_c  = '0;
        have_c = 1'b0;
        for (int i = MAX_BUFFERS - 1; i >= 0; i--)
        begin
            if ((i < 32'(nbuf)) && !busy_reg[i])
            begin
                sel_c  = BW'(i);
                have_c = 1'b1;
            end
        end
    end

    // version bump with wrap to one
    always_comb
    begin
        ver_next = ver_reg + VW'(1);
        if (ver_next == '0)
            ver_next = VW'(1);
    end

    // tile compare and update
    assign scan_addr = base_reg + AW'(x_reg);
    assign buf_sel_q = buf_q[sel_reg];
    assign cov       = (px_reg < r_reg) && ((px_reg + TS) > l_reg) &&
                       (py_reg < b_reg) && ((py_reg + TS) > t_reg);
    assign new_cur   = cov ? ver_reg : cur_q;
    assign diff      = have_buf_reg && (buf_sel_q != new_cur);
    assign mask_cur  = mask_reg | (diff ? (32'd1 << x_reg) : 32'd0);
    assign row_end   = (px_reg + TS) >= w_eff;
    assign grid_end  = row_end && ((py_reg + TS) >= h_eff);
    assign cur_we    = cmd.clr_step || (cmd.scan_wr && cov);
    assign waddr     = cmd.clr_step ? clr_addr_reg : scan_addr;

    // tile version memories
    dtvt_ram #(
        .WIDTH (VW),
        .DEPTH (TILE_COUNT)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (waddr),
        .wdata (cmd.clr_step ? VW'(1) : ver_reg),
        .raddr (scan_addr),
        .rdata (cur_q)
    );

    for (genvar g = 0; g < MAX_BUFFERS; g++)
    begin : g_buf
        dtvt_ram #(
            .WIDTH (VW),
            .DEPTH (TILE_COUNT)
        ) u_buf_ram (
            .clk   (clk),
            .we    (cmd.clr_step || (cmd.scan_wr && diff && (sel_reg == BW'(g)))),
            .waddr (waddr),
            .wdata (cmd.clr_step ? '0 : new_cur),
            .raddr (scan_addr),
            .rdata (buf_q[g])
        );
    end

    // configuration, version and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= dtvt_pkg::RST_FRAME_WIDTH;
            height_reg   <= dtvt_pkg::RST_FRAME_HEIGHT;
            bcount_reg   <= dtvt_pkg::RST_BUFFER_COUNT;
            ver_reg      <= VW'(1);
            ffp_reg      <= 1'b1;
            busy_reg     <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dtvt_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    dtvt_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    dtvt_pkg::CFG_BUFFER_COUNT: bcount_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (cfg_clear)
            begin
                ver_reg      <= VW'(1);
                ffp_reg      <= 1'b1;
                clr_addr_reg <= '0;
            end
            else
            begin
                if (cmd.clr_step)
                begin
                    clr_addr_reg <= sts.clr_done ? '0 : clr_addr_reg + AW'(1);
                end
                if (cmd.bump)
                begin
                    ver_reg <= ver_next;
                end
                if (cmd.load && !mode)
                begin
                    ffp_reg <= 1'b0;
                end
            end
            // release frees a buffer, a finished scan takes one
            for (int i = 0; i < MAX_BUFFERS; i++)
            begin
                if (cmd.load && mode && (release_index == 2'(i)))
                    busy_reg[i] <= 1'b0;
                if (cmd.scan_wr && grid_end && have_buf_reg && (sel_reg == BW'(i)))
                    busy_reg[i] <= 1'b1;
            end
        end
    end

    // item capture and scan counters
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            rel_idx_reg <= release_index;
            if (ffp_reg)
            begin
                l_reg <= '0;
                t_reg <= '0;
                r_reg <= w_eff;
                b_reg <= h_eff;
            end
            else
            begin
                l_reg <= PW'(unsigned'(cl));
                t_reg <= PW'(unsigned'(ct));
                r_reg <= PW'(unsigned'(cr));
                b_reg <= PW'(unsigned'(cb));
            end
        end
        if (cmd.scan_init)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            base_reg     <= '0;
            mask_reg     <= '0;
            sel_reg      <= sel_c;
            have_buf_reg <= have_c;
        end
        else if (cmd.scan_wr)
        begin
            if (row_end)
            begin
                x_reg    <= '0;
                px_reg   <= '0;
                y_reg    <= y_reg + YW'(1);
                py_reg   <= py_reg + TS;
                base_reg <= base_reg + AW'(MAX_TILE_COLUMNS);
                mask_reg <= '0;
            end
            else
            begin
                x_reg    <= x_reg + XW'(1);
                px_reg   <= px_reg + TS;
                mask_reg <= mask_cur;
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit_release || cmd.emit_empty ||
                             (cmd.scan_wr && row_end && have_buf_reg) ||
                             (cmd.scan_wr && grid_end && !have_buf_reg);
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.emit_release)
        begin
            status_reg        <= dtvt_pkg::ST_RELEASE;
            buffer_index_reg  <= rel_idx_reg;
            tile_row_reg      <= '0;
            column_mask_reg   <= '0;
            damage_left_reg   <= '0;
            damage_top_reg    <= '0;
            damage_width_reg  <= '0;
            damage_height_reg <= '0;
            last_reg          <= 1'b1;
        end
        else if (cmd.emit_empty || cmd.scan_wr)
        begin
            damage_left_reg   <= 12'(l_reg);
            damage_top_reg    <= 12'(t_reg);
            damage_width_reg  <= 12'(r_reg - l_reg);
            damage_height_reg <= 12'(b_reg - t_reg);
            if (cmd.emit_empty || !have_buf_reg)
            begin
                status_reg       <= cmd.emit_empty ? dtvt_pkg::ST_EMPTY : dtvt_pkg::ST_NOBUF;
                buffer_index_reg <= '0;
                tile_row_reg     <= '0;
                column_mask_reg  <= '0;
                last_reg         <= 1'b1;
            end
            else
            begin
                status_reg       <= dtvt_pkg::ST_ROWS;
                buffer_index_reg <= 2'(sel_reg);
                tile_row_reg     <= 5'(y_reg);
                column_mask_reg  <= mask_cur;
                last_reg         <= grid_end;
            end
        end
    end

    assign sts.cfg_clear  = cfg_clear;
    assign sts.clr_done   = (clr_addr_reg == AW'(TILE_COUNT - 1));
    assign sts.is_release = mode_reg;
    assign sts.is_empty   = (r_reg <= l_reg) || (b_reg <= t_reg);
    assign sts.wrap       = (ver_next == VW'(1));
    assign sts.grid_end   = grid_end;

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign buffer_index  = buffer_index_reg;
    assign tile_row      = tile_row_reg;
    assign column_mask   = column_mask_reg;
    assign damage_left   = damage_left_reg;
    assign damage_top    = damage_top_reg;
    assign damage_width  = damage_width_reg;
    assign damage_height = damage_height_reg;
    assign last          = last_reg;

endmodule

/* rtl/damage_tile_version_tracker.sv */
// channel   ports                                        handshake
// ------    -----                                        ---------
// input     mode, rect_*, release_index                  start & !busy
// result    status .. last                               out_valid, one cycle
// config    cfg_we, cfg_index, cfg_data                  cfg_we
//
// a release or an empty rectangle gives its word once the item registered on
// start has been evaluated. a present scans the tile grid of the frame, each
// tile in a read state and a write state (registered read of the version
// memories), one word per tile row, or a single no-buffer word when no buffer is
// free. a version wrap first runs a clearing pass over the memories. after reset
// and after a frame size write a clearing pass runs with busy high; words cannot be stalled by the receiver.
module damage_tile_version_tracker #(
    parameter int TILE_SIZE        = dtvt_pkg::DEF_TILE_SIZE,
    parameter int MAX_TILE_COLUMNS = dtvt_pkg::DEF_MAX_TILE_COLUMNS,
    parameter int MAX_TILE_ROWS    = dtvt_pkg::DEF_MAX_TILE_ROWS,
    parameter int MAX_BUFFERS      = dtvt_pkg::DEF_MAX_BUFFERS,
    parameter int VERSION_BITS     = dtvt_pkg::DEF_VERSION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic signed [15:0] rect_left,
    input  logic signed [15:0] rect_top,
    input  logic signed [15:0] rect_right,
    input  logic signed [15:0] rect_bottom,
    input  logic [1:0]         release_index,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic [1:0]         buffer_index,
    output logic [4:0]         tile_row,
    output logic [31:0]        column_mask,
    output logic [11:0]        damage_left,
    output logic [11:0]        damage_top,
    output logic [11:0]        damage_width,
    output logic [11:0]        damage_height,
    output logic               last
);

    dtvt_pkg::cmd_t cmd;
    dtvt_pkg::sts_t sts;

    // sequencer
    dtvt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // tile memories, counters and result word
    dtvt_datapath #(
        .TILE_SIZE        (TILE_SIZE),
        .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS),
        .MAX_TILE_ROWS    (MAX_TILE_ROWS),
        .MAX_BUFFERS      (MAX_BUFFERS),
        .VERSION_BITS     (VERSION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .rect_left     (rect_left),
        .rect_top      (rect_top),
        .rect_right    (rect_right),
        .rect_bottom   (rect_bottom),
        .release_index (release_index),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .status        (status),
        .buffer_index  (buffer_index),
        .tile_row      (tile_row),
        .column_mask   (column_mask),
        .damage_left   (damage_left),
        .damage_top    (damage_top),
        .damage_width  (damage_width),
        .damage_height (damage_height),
        .last          (last)
    );

endmodule

/* tb/damage_tile_version_tracker_tb.sv */
`timescale 1ns / 1ps

module damage_tile_version_tracker_tb;

    localparam int TILE      = 64;
    localparam int COLS_MAX  = 32;
    localparam int ROWS_MAX  = 32;
    localparam int NUM_BUF   = 3;
    localparam int GRID      = COLS_MAX * ROWS_MAX;
    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        logic [1:0]  st;
        logic [1:0]  buf_idx;
        logic [4:0]  row;
        logic [31:0] mask;
        logic [11:0] dl;
        logic [11:0] dt;
        logic [11:0] dw;
        logic [11:0] dh;
        logic        lst;
    } tracker_word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [11:0]        cfg_data;
    logic               start;
    logic               busy;
    logic               mode;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
    logic [1:0]         release_index;
    logic               out_valid;
    logic [1:0]         status;
    logic [1:0]         buffer_index;
    logic [4:0]         tile_row;
    logic [31:0]        column_mask;
    logic [11:0]        damage_left;
    logic [11:0]        damage_top;
    logic [11:0]        damage_width;
    logic [11:0]        damage_height;
    logic               last;

    // tracker state mirror
    logic [15:0] tile_ver [GRID];
    logic [15:0] copy_ver [NUM_BUF][GRID];
    logic [15:0] ver_count;
    logic        buf_held [NUM_BUF];
    logic        full_pending;
    logic [11:0] reg_width;
    logic [11:0] reg_height;
    logic [1:0]  reg_bufs;

    tracker_word_t expected_words[$];
    int error_count;
    int idle_cycles;
    int send_gap_pct;

    damage_tile_version_tracker dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .mode(mode),
        .rect_left(rect_left), .rect_top(rect_top), .rect_right(rect_right),
        .rect_bottom(rect_bottom), .release_index(release_index),
        .out_valid(out_valid), .status(status), .buffer_index(buffer_index),
        .tile_row(tile_row), .column_mask(column_mask),
        .damage_left(damage_left), .damage_top(damage_top),
        .damage_width(damage_width), .damage_height(damage_height),
        .last(last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // wipe versions, as on reset, size change or wrap
    task automatic clear_grid();
        for (int i = 0; i < GRID; i++)
        begin
            tile_ver[i] = 16'd1;
            for (int b = 0; b < NUM_BUF; b++)
                copy_ver[b][i] = 16'd0;
        end
    endtask

    function automatic int frame_dim(logic [11:0] v);
        int d;
        d = int'(v);
        if (d < 1)
            d = 1;
        if (d > COLS_MAX * TILE)
            d = COLS_MAX * TILE;
        return d;
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic tracker_word_t make_word(logic [1:0] st, logic [1:0] bi,
                                                int row, logic [31:0] mask,
                                                int l, int t, int w, int h,
                                                logic lst);
        tracker_word_t wd;
        wd.st = st;
        wd.buf_idx = bi;
        wd.row = row[4:0];
        wd.mask = mask;
        wd.dl = l[11:0];
        wd.dt = t[11:0];
        wd.dw = w[11:0];
        wd.dh = h[11:0];
        wd.lst = lst;
        return wd;
    endfunction

    // append one expected word
    task automatic queue_word(tracker_word_t wd);
        expected_words.insert(expected_words.size(), wd);
    endtask

    // expected words for one accepted item
    task automatic predict_damage(logic md, logic signed [15:0] rl,
                                  logic signed [15:0] rt, logic signed [15:0] rr,
                                  logic signed [15:0] rb, logic [1:0] ri);
        int fw;
        int fh;
        int cols;
        int rows;
        int l;
        int t;
        int r;
        int bt;
        int nb;
        int sel;
        logic [31:0] mask;
        fw = frame_dim(reg_width);
        fh = frame_dim(reg_height);
        cols = (fw + TILE - 1) / TILE;
        rows = (fh + TILE - 1) / TILE;
        if (md)
        begin
            if (ri < NUM_BUF)
                buf_held[ri] = 1'b0;
            queue_word(make_word(dtvt_pkg::ST_RELEASE, ri, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
        end
        if (full_pending)
        begin
            full_pending = 1'b0;
            l = 0; t = 0; r = fw; bt = fh;
        end
        else
        begin
            l = clamp_int(int'(rl), 0, fw);
            t = clamp_int(int'(rt), 0, fh);
            r = clamp_int(int'(rr), l, fw);
            bt = clamp_int(int'(rb), t, fh);
        end
        if (r <= l || bt <= t)
        begin
            queue_word(make_word(dtvt_pkg::ST_EMPTY, 0, 0, 0, l, t, r - l, bt - t, 1'b1));
            return;
        end
        ver_count = ver_count + 16'd1;
        if (ver_count == 16'd0)
        begin
            ver_count = 16'd1;
            clear_grid();
        end
        for (int y = t / TILE; y <= (bt - 1) / TILE; y++)
            for (int x = l / TILE; x <= (r - 1) / TILE; x++)
                tile_ver[y * COLS_MAX + x] = ver_count;
        nb = int'(reg_bufs);
        if (nb < 2)
            nb = 2;
        if (nb > NUM_BUF)
            nb = NUM_BUF;
        sel = -1;
        for (int b = nb - 1; b >= 0; b--)
            if (!buf_held[b])
                sel = b;
        if (sel < 0)
        begin
            queue_word(make_word(dtvt_pkg::ST_NOBUF, 0, 0, 0, l, t, r - l, bt - t, 1'b1));
            return;
        end
        for (int y = 0; y < rows; y++)
        begin
            mask = '0;
            for (int x = 0; x < cols; x++)
            begin
                if (copy_ver[sel][y * COLS_MAX + x] != tile_ver[y * COLS_MAX + x])
                begin
                    mask[x] = 1'b1;
                    copy_ver[sel][y * COLS_MAX + x] = tile_ver[y * COLS_MAX + x];
                end
            end
            queue_word(make_word(dtvt_pkg::ST_ROWS, sel[1:0], y, mask, l, t,
                                 r - l, bt - t, y == rows - 1));
        end
        buf_held[sel] = 1'b1;
    endtask

    // send one item and wait for it to be taken
    task automatic send_item(logic md, int rl, int rt, int rr, int rb, int ri);
        if ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        mode <= md;
        rect_left <= rl[15:0];
        rect_top <= rt[15:0];
        rect_right <= rr[15:0];
        rect_bottom <= rb[15:0];
        release_index <= ri[1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_damage(md, rl[15:0], rt[15:0], rr[15:0], rb[15:0], ri[1:0]);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // register write while idle
    task automatic write_reg(logic [1:0] idx, int val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[11:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == dtvt_pkg::CFG_FRAME_WIDTH || idx == dtvt_pkg::CFG_FRAME_HEIGHT)
        begin
            if (idx == dtvt_pkg::CFG_FRAME_WIDTH)
                reg_width = val[11:0];
            else
                reg_height = val[11:0];
            clear_grid();
            ver_count = 16'd1;
            full_pending = 1'b1;
        end
        else if (idx == dtvt_pkg::CFG_BUFFER_COUNT)
            reg_bufs = val[1:0];
        repeat (3) @(posedge clk);
    endtask

    task automatic release_all();
        for (int b = 0; b < NUM_BUF; b++)
            send_item(1'b1, 0, 0, 0, 0, b);
    endtask

    // directed: first present after reset uses the full frame
    task automatic test_full_frame();
        send_item(1'b0, 5, 5, 6, 6, 0);
        send_item(1'b0, -32768, -32768, 32767, 32767, 0);
    endtask

    // directed: empty and inverted rectangles
    task automatic test_empty_damage();
        send_item(1'b0, 100, 100, 100, 200, 0);
        send_item(1'b0, 300, 50, 50, 400, 0);
        send_item(1'b0, 32767, 32767, 32767, 32767, 0);
    endtask

    // directed: exhaust buffers, then release each index
    task automatic test_buffer_ring();
        send_item(1'b0, -5, -5, 70, 10, 0);
        send_item(1'b0, 600, 400, 32767, 32767, 0);
        send_item(1'b0, 0, 0, 1, 1, 0);
        for (int b = 0; b < 4; b++)
            send_item(1'b1, 0, 0, 0, 0, b);
        send_item(1'b0, 63, 63, 65, 65, 0);
    endtask

    // directed: register extremes
    task automatic test_register_extremes();
        write_reg(dtvt_pkg::CFG_BUFFER_COUNT, 0);
        send_item(1'b0, 0, 0, 10, 10, 0);
        send_item(1'b0, 0, 0, 10, 10, 0);
        send_item(1'b0, 0, 0, 10, 10, 0);
        release_all();
        write_reg(dtvt_pkg::CFG_BUFFER_COUNT, 1);
        write_reg(dtvt_pkg::CFG_FRAME_WIDTH, 0);
        write_reg(dtvt_pkg::CFG_FRAME_HEIGHT, 0);
        send_item(1'b0, 0, 0, 1, 1, 0);
        send_item(1'b0, 0, 0, 1, 1, 0);
        release_all();
        write_reg(dtvt_pkg::CFG_FRAME_WIDTH, 4095);
        write_reg(dtvt_pkg::CFG_FRAME_HEIGHT, 4095);
        write_reg(dtvt_pkg::CFG_BUFFER_COUNT, 3);
        send_item(1'b0, 0, 0, 0, 0, 0);
        send_item(1'b0, 2000, 2000, 2100, 2100, 0);
        release_all();
    endtask

    function automatic int pick_coord(int dim);
        if ($urandom_range(9) < 8)
            return $urandom_range(dim + 80) - 40;
        return int'($signed($urandom_range(16'hffff, 0) & 16'hffff)) - 0;
    endfunction

    // random items over two frame settings
    task automatic test_random(int pct, int n);
        int fw;
        int fh;
        int l;
        int t;
        send_gap_pct = pct;
        for (int seg = 0; seg < 2; seg++)
        begin
            if ($urandom_range(4) == 0)
            begin
                write_reg(dtvt_pkg::CFG_FRAME_WIDTH, $urandom_range(1, 2048));
                write_reg(dtvt_pkg::CFG_FRAME_HEIGHT, $urandom_range(1, 2048));
            end
            else
            begin
                write_reg(dtvt_pkg::CFG_FRAME_WIDTH, $urandom_range(1, 400));
                write_reg(dtvt_pkg::CFG_FRAME_HEIGHT, $urandom_range(1, 400));
            end
            write_reg(dtvt_pkg::CFG_BUFFER_COUNT, $urandom_range(0, 3));
            fw = frame_dim(reg_width);
            fh = frame_dim(reg_height);
            for (int k = 0; k < n / 2; k++)
            begin
                if ($urandom_range(3) == 0)
                    send_item(1'b1, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(3));
                else if ($urandom_range(9) == 0)
                    send_item(1'b0, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(3));
                else
                begin
                    l = pick_coord(fw);
                    t = pick_coord(fh);
                    send_item(1'b0, l, t, l + $urandom_range(fw), t + $urandom_range(fh),
                              $urandom_range(3));
                end
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        tracker_word_t exp_w;
        if (rst_n && out_valid)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: status %0d", status);
                error_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (status !== exp_w.st)
                begin
                    $error("status: expected %0d, got %0d", exp_w.st, status);
                    error_count++;
                end
                if (buffer_index !== exp_w.buf_idx)
                begin
                    $error("buffer_index: expected %0d, got %0d", exp_w.buf_idx, buffer_index);
                    error_count++;
                end
                if (tile_row !== exp_w.row)
                begin
                    $error("tile_row: expected %0d, got %0d", exp_w.row, tile_row);
                    error_count++;
                end
                if (column_mask !== exp_w.mask)
                begin
                    $error("column_mask: expected %h, got %h", exp_w.mask, column_mask);
                    error_count++;
                end
                if (damage_left !== exp_w.dl)
                begin
                    $error("damage_left: expected %0d, got %0d", exp_w.dl, damage_left);
                    error_count++;
                end
                if (damage_top !== exp_w.dt)
                begin
                    $error("damage_top: expected %0d, got %0d", exp_w.dt, damage_top);
                    error_count++;
                end
                if (damage_width !== exp_w.dw)
                begin
                    $error("damage_width: expected %0d, got %0d", exp_w.dw, damage_width);
                    error_count++;
                end
                if (damage_height !== exp_w.dh)
                begin
                    $error("damage_height: expected %0d, got %0d", exp_w.dh, damage_height);
                    error_count++;
                end
                if (last !== exp_w.lst)
                begin
                    $error("last: expected %0d, got %0d", exp_w.lst, last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((start && !busy) || out_valid || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        mode = 1'b0;
        rect_left = '0;
        rect_top = '0;
        rect_right = '0;
        rect_bottom = '0;
        release_index = '0;
        error_count = 0;
        idle_cycles = 0;
        send_gap_pct = 0;
        clear_grid();
        ver_count = 16'd1;
        for (int b = 0; b < NUM_BUF; b++)
            buf_held[b] = 1'b0;
        full_pending = 1'b1;
        reg_width = dtvt_pkg::RST_FRAME_WIDTH;
        reg_height = dtvt_pkg::RST_FRAME_HEIGHT;
        reg_bufs = dtvt_pkg::RST_BUFFER_COUNT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_frame();
        test_empty_damage();
        test_buffer_ring();
        test_register_extremes();
        test_random(7, 86);
        test_random(56, 86);
        test_random(0, 86);

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dtvt_pkg.sv
rtl/dtvt_ram.sv
rtl/dtvt_ctrl.sv
rtl/dtvt_datapath.sv
rtl/damage_tile_version_tracker.sv
tb/damage_tile_version_tracker_tb.sv
